// ===== rtl/core/vsdzq_pkg.sv =====
// Shared types and codes for the voxel store with dirty zone queue.
// Item structs, command codes, zone box layout, ring control bundle.
// No dependencies.
`default_nettype none

package vsdzq_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_PUSH  = 2'd2,
		CMD_POP   = 2'd3
	} cmd_t;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_DEPTH  = 2'd2;
	localparam logic [1:0] CFG_VACUUM = 2'd3;

	localparam int COORD_W = 6;
	localparam int SIZE_W  = 7;
	localparam int VALUE_W = 16;

	typedef struct packed {
		logic signed [7:0] lo_x;
		logic signed [7:0] lo_y;
		logic signed [7:0] lo_z;
		logic signed [7:0] hi_x;
		logic signed [7:0] hi_y;
		logic signed [7:0] hi_z;
	} box_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [COORD_W-1:0]   point_x;
		logic [COORD_W-1:0]   point_y;
		logic [COORD_W-1:0]   point_z;
		logic [VALUE_W-1:0]   write_value;
		logic signed [7:0]    zone_lo_x;
		logic signed [7:0]    zone_lo_y;
		logic signed [7:0]    zone_lo_z;
		logic signed [7:0]    zone_hi_x;
		logic signed [7:0]    zone_hi_y;
		logic signed [7:0]    zone_hi_z;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]   read_value;
		logic                 out_of_range;
		logic                 zone_valid;
		logic signed [7:0]    out_lo_x;
		logic signed [7:0]    out_lo_y;
		logic signed [7:0]    out_lo_z;
		logic signed [7:0]    out_hi_x;
		logic signed [7:0]    out_hi_y;
		logic signed [7:0]    out_hi_z;
	} out_item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/voxel_store_dirty_zone_queue_core.sv =====
// Voxel store of the finest level with a ring of dirty zones.
// Top level: size registers, address pipeline, voxel memory, result register.
// Depends on vsdzq_pkg and vsdzq_ring.
//
// One command is taken at a time. The h*z+y multiply runs in the accepting
// cycle; the ADDR step then forms w*(...)+x, the MEM step accesses the voxel
// or ring memory, and the RES step builds the result and loads it into the
// output register. The next command is accepted once the result is loaded; a
// stalled waiting result holds the core in its result step. Each voxel entry
// carries a written mark next to its data; after reset a clearing pass runs
// over all MAX_EDGE^3 entries (262144 at the default size) with in_stall
// high. Configuration must be written only while no command is in flight;
// the core itself does not enforce this. Results wait in an output register,
// and the next command is accepted while one waits.
`default_nettype none

module voxel_store_dirty_zone_queue_core #(
	parameter int VOXEL_BITS = 16,
	parameter int ZONE_SLOTS = 16,
	parameter int MAX_EDGE   = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  vsdzq_pkg::in_item_t   in_item,
	output logic                  out_valid,
	input  wire                   out_stall,
	output vsdzq_pkg::out_item_t  out_item,
	input  wire                   cfg_we,
	input  wire  [1:0]            cfg_index,
	input  wire  [15:0]           cfg_data
);
	import vsdzq_pkg::*;

	localparam int CELLS  = MAX_EDGE * MAX_EDGE * MAX_EDGE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SZ_W   = $clog2(MAX_EDGE + 1);
	localparam int CMP_W  = (SZ_W > SIZE_W) ? SZ_W : SIZE_W;
	localparam int YZ_W   = $clog2(MAX_EDGE * MAX_EDGE);
	localparam int YZF_W  = SZ_W + COORD_W + 1;
	localparam int ADF_W  = SZ_W + YZ_W + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_MEM,
		ST_RES
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [SIZE_W-1:0]  depth_q;
	logic [VALUE_W-1:0] vacuum_q;

	logic [ADDR_W-1:0]  clr_q;

	cmd_t               cmd_s1;
	logic [COORD_W-1:0] px_s1;
	logic [COORD_W-1:0] py_s1;
	logic [COORD_W-1:0] pz_s1;
	logic [VALUE_W-1:0] wv_s1;
	box_t               zone_s1;
	logic               oor_s1;
	logic [YZ_W-1:0]    yz_s1;
	logic [ADDR_W-1:0]  addr_s2;

	logic [VOXEL_BITS:0] vox_mem [CELLS];
	logic [VOXEL_BITS:0] vox_rd_q;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_wa;
	logic [VOXEL_BITS:0] mem_wd;

	logic [SZ_W-1:0]    w_eff;
	logic [SZ_W-1:0]    h_eff;
	logic [SZ_W-1:0]    d_eff;
	logic               oor_d;
	logic [YZF_W-1:0]   yz_full;
	logic [ADF_W-1:0]   addr_full;
	logic               accept;

	ring_ctl_t          ring_ctl;
	box_t               push_box;
	box_t               pop_box;
	logic               pop_hit;

	out_item_t          res_d;
	out_item_t          out_q;
	logic               out_valid_q;
	logic               load_out;

	function automatic logic [SZ_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		eff_size = (CMP_W'(s) > CMP_W'(MAX_EDGE)) ? SZ_W'(MAX_EDGE) : SZ_W'(s);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			depth_q  <= '0;
			vacuum_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				CFG_DEPTH:  depth_q  <= cfg_data[SIZE_W-1:0];
				CFG_VACUUM: vacuum_q <= cfg_data;
			endcase
		end
	end

	assign w_eff = eff_size(width_q);
	assign h_eff = eff_size(height_q);
	assign d_eff = eff_size(depth_q);

	assign oor_d = (CMP_W'(in_item.point_x) >= CMP_W'(w_eff)) ||
	               (CMP_W'(in_item.point_y) >= CMP_W'(h_eff)) ||
	               (CMP_W'(in_item.point_z) >= CMP_W'(d_eff));

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign yz_full   = YZF_W'(h_eff) * YZF_W'(in_item.point_z) + YZF_W'(in_item.point_y);
	assign addr_full = ADF_W'(w_eff) * ADF_W'(yz_s1) + ADF_W'(px_s1);

	// address pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= in_item.cmd;
			px_s1        <= in_item.point_x;
			py_s1        <= in_item.point_y;
			pz_s1        <= in_item.point_z;
			wv_s1        <= in_item.write_value;
			zone_s1.lo_x <= in_item.zone_lo_x;
			zone_s1.lo_y <= in_item.zone_lo_y;
			zone_s1.lo_z <= in_item.zone_lo_z;
			zone_s1.hi_x <= in_item.zone_hi_x;
			zone_s1.hi_y <= in_item.zone_hi_y;
			zone_s1.hi_z <= in_item.zone_hi_z;
			oor_s1       <= oor_d;
			yz_s1        <= yz_full[YZ_W-1:0];
		end
		if (state_q == ST_ADDR) begin
			addr_s2 <= addr_full[ADDR_W-1:0];
		end
	end

	// voxel memory: {written mark, data}
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s2;
		mem_wd = {1'b1, VOXEL_BITS'(wv_s1)};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == ST_MEM && cmd_s1 == CMD_WRITE && !oor_s1) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vox_mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_MEM) begin
			vox_rd_q <= vox_mem[addr_s2];
		end
	end

	// zone ring
	always_comb begin
		ring_ctl.push = 1'b0;
		ring_ctl.pop  = 1'b0;
		if (state_q == ST_MEM) begin
			ring_ctl.push = (cmd_s1 == CMD_PUSH) || (cmd_s1 == CMD_WRITE && !oor_s1);
			ring_ctl.pop  = (cmd_s1 == CMD_POP);
		end
		if (cmd_s1 == CMD_PUSH) begin
			push_box = zone_s1;
		end else begin
			push_box.lo_x = 8'(px_s1);
			push_box.lo_y = 8'(py_s1);
			push_box.lo_z = 8'(pz_s1);
			push_box.hi_x = 8'(px_s1) + 8'd1;
			push_box.hi_y = 8'(py_s1) + 8'd1;
			push_box.hi_z = 8'(pz_s1) + 8'd1;
		end
	end

	vsdzq_ring #(
		.SLOTS (ZONE_SLOTS)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ring_ctl),
		.push_box (push_box),
		.pop_box  (pop_box),
		.pop_hit  (pop_hit)
	);

	// result
	always_comb begin
		res_d = '0;
		unique case (cmd_s1)
			CMD_WRITE: begin
				res_d.out_of_range = oor_s1;
			end
			CMD_READ: begin
				res_d.out_of_range = oor_s1;
				if (!oor_s1 && vox_rd_q[VOXEL_BITS]) begin
					res_d.read_value = VALUE_W'(vox_rd_q[VOXEL_BITS-1:0]);
				end else begin
					res_d.read_value = vacuum_q;
				end
			end
			CMD_PUSH: begin
			end
			CMD_POP: begin
				if (pop_hit) begin
					res_d.zone_valid = 1'b1;
					res_d.out_lo_x   = pop_box.lo_x;
					res_d.out_lo_y   = pop_box.lo_y;
					res_d.out_lo_z   = pop_box.lo_z;
					res_d.out_hi_x   = pop_box.hi_x;
					res_d.out_hi_y   = pop_box.hi_y;
					res_d.out_hi_z   = pop_box.hi_z;
				end
			end
		endcase
	end

	assign load_out = (state_q == ST_RES) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_q       <= res_d;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_MEM;
				ST_MEM:  state_q <= ST_RES;
				ST_RES: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/vsdzq_ring.sv =====
// Zone ring: synchronous box memory with head and tail pointers.
// Pop data and hit flag are registered, valid in the cycle after the pop request.
// Depends on vsdzq_pkg.
`default_nettype none

module vsdzq_ring #(
	parameter int SLOTS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  vsdzq_pkg::ring_ctl_t  ctl,
	input  vsdzq_pkg::box_t       push_box,
	output vsdzq_pkg::box_t       pop_box,
	output logic                  pop_hit
);
	import vsdzq_pkg::*;

	localparam int PTR_W = $clog2(SLOTS);

	box_t             ring_mem [SLOTS];
	box_t             rd_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic             hit_q;
	logic             nonempty;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	assign nonempty = (head_q != tail_q);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ring_mem[tail_q] <= push_box;
		end
		if (ctl.pop) begin
			rd_q <= ring_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (ctl.pop) begin
				hit_q <= nonempty;
			end
			if (ctl.push) begin
				tail_q <= next_ptr(tail_q);
			end
			if (ctl.pop && nonempty) begin
				head_q <= next_ptr(head_q);
			end
		end
	end

	assign pop_box = rd_q;
	assign pop_hit = hit_q;

endmodule

`default_nettype wire

// ===== rtl/core/vsdzq_checker.sv =====
// Port-level checks for the voxel store core, bound to the top level.
// Depends on vsdzq_pkg and voxel_store_dirty_zone_queue_core.
`default_nettype none

module vsdzq_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_stall,
	input wire                   out_valid,
	input wire                   out_stall,
	input vsdzq_pkg::out_item_t  out_item
);
	import vsdzq_pkg::*;

	// one item in flight: stall rises right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item accepted while previous item in flight");

	// a popped box never carries point results
	a_pop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.zone_valid) |->
			(out_item.read_value == '0 && !out_item.out_of_range))
		else $error("popped zone with point result fields set");

	// box fields are zero unless a box was popped
	a_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.zone_valid) |->
			(out_item.out_lo_x == '0 && out_item.out_lo_y == '0 &&
			 out_item.out_lo_z == '0 && out_item.out_hi_x == '0 &&
			 out_item.out_hi_y == '0 && out_item.out_hi_z == '0))
		else $error("box fields nonzero without a popped zone");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled result changed or dropped");

endmodule

bind voxel_store_dirty_zone_queue_core vsdzq_checker u_vsdzq_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for voxel_store_dirty_zone_queue_core: directed table, then random phases.
// Expected results: typed rows, else an in-bench predictor of voxel store and ring.
// Depends on vsdzq_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
	import vsdzq_pkg::*;

	localparam int QUIET_LIMIT  = 800_000;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 145;
	localparam int RECENT_DEPTH = 32;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		logic [15:0] reg_data;
		in_item_t    item;
		int          reps;
		bit          typed;
		out_item_t   want;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	// predictor state
	logic [6:0]  size_w = '0;
	logic [6:0]  size_h = '0;
	logic [6:0]  size_d = '0;
	logic [15:0] vacuum = '0;
	logic [15:0] voxel_mem [int unsigned];
	box_t        zone_ring [16];
	logic [3:0]  ring_head = '0;
	logic [3:0]  ring_tail = '0;

	out_item_t   due_results [$];
	logic [17:0] recent [$];
	stim_row_t   script [$];
	int          errors      = 0;
	int          gap_pct     = 20;
	int          stall_pct   = 20;
	int          push_pct    = 15;
	bit          calm        = 1'b0;
	int          stall_left  = 0;
	int          quiet_count = 0;

	voxel_store_dirty_zone_queue_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int clip_size(logic [6:0] s);
		return (s > 7'd64) ? 64 : int'(s);
	endfunction

	function automatic out_item_t apply_command(in_item_t it);
		out_item_t   r;
		box_t        b;
		int          w;
		int          h;
		int          d;
		bit          in_size;
		int unsigned addr;
		r = '0;
		w = clip_size(size_w);
		h = clip_size(size_h);
		d = clip_size(size_d);
		in_size = (it.point_x < w) && (it.point_y < h) && (it.point_z < d);
		addr = it.point_x + w * (it.point_y + h * it.point_z);
		case (it.cmd)
			CMD_WRITE: begin
				if (in_size) begin
					voxel_mem[addr] = it.write_value;
					b.lo_x = 8'(it.point_x);
					b.lo_y = 8'(it.point_y);
					b.lo_z = 8'(it.point_z);
					b.hi_x = 8'(it.point_x) + 8'd1;
					b.hi_y = 8'(it.point_y) + 8'd1;
					b.hi_z = 8'(it.point_z) + 8'd1;
					zone_ring[ring_tail] = b;
					ring_tail++;
				end else begin
					r.out_of_range = 1'b1;
				end
			end
			CMD_READ: begin
				r.out_of_range = !in_size;
				r.read_value = (in_size && voxel_mem.exists(addr)) ? voxel_mem[addr] : vacuum;
			end
			CMD_PUSH: begin
				zone_ring[ring_tail] = {it.zone_lo_x, it.zone_lo_y, it.zone_lo_z,
					it.zone_hi_x, it.zone_hi_y, it.zone_hi_z};
				ring_tail++;
			end
			default: begin
				if (ring_head != ring_tail) begin
					b = zone_ring[ring_head];
					ring_head++;
					r.zone_valid = 1'b1;
					r.out_lo_x = b.lo_x;
					r.out_lo_y = b.lo_y;
					r.out_lo_z = b.lo_z;
					r.out_hi_x = b.hi_x;
					r.out_hi_y = b.hi_y;
					r.out_hi_z = b.hi_z;
				end
			end
		endcase
		return r;
	endfunction

	function automatic in_item_t point_cmd(cmd_t c, logic [5:0] x, logic [5:0] y,
			logic [5:0] z, logic [15:0] v);
		return {c, x, y, z, v, 48'b0};
	endfunction

	function automatic in_item_t zone_cmd(cmd_t c, box_t b);
		return {c, 34'b0, b};
	endfunction

	function automatic out_item_t flags_result(logic [15:0] v, logic oor);
		out_item_t r;
		r = '0;
		r.read_value = v;
		r.out_of_range = oor;
		return r;
	endfunction

	function automatic stim_row_t row_item(in_item_t it, int n);
		stim_row_t s;
		s = '{default: '0};
		s.item = it;
		s.reps = n;
		return s;
	endfunction

	function automatic stim_row_t row_typed(in_item_t it, out_item_t w);
		stim_row_t s;
		s = row_item(it, 1);
		s.typed = 1'b1;
		s.want = w;
		return s;
	endfunction

	function automatic stim_row_t row_reg(logic [1:0] idx, logic [15:0] data);
		stim_row_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.reg_idx = idx;
		s.reg_data = data;
		return s;
	endfunction

	function automatic logic [5:0] pick_coord(logic [6:0] s);
		int e;
		e = clip_size(s);
		if (e > 0 && $urandom_range(0, 9) != 0)
			return 6'($urandom_range(0, e - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic in_item_t random_command();
		in_item_t    it;
		logic [95:0] raw;
		int          pick;
		raw = {$urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 35)
			it.cmd = CMD_WRITE;
		else if (pick < 65)
			it.cmd = CMD_READ;
		else if (pick < 65 + push_pct)
			it.cmd = CMD_PUSH;
		else
			it.cmd = CMD_POP;
		it.point_x = pick_coord(size_w);
		it.point_y = pick_coord(size_h);
		it.point_z = pick_coord(size_d);
		// reads lean on recently written points so stored data gets hit
		if (it.cmd == CMD_READ && recent.size() != 0 && $urandom_range(0, 1) == 1)
			{it.point_x, it.point_y, it.point_z} = recent[$urandom_range(0, recent.size() - 1)];
		if (it.cmd == CMD_WRITE) begin
			recent.push_back({it.point_x, it.point_y, it.point_z});
			if (recent.size() > RECENT_DEPTH)
				void'(recent.pop_front());
		end
		return it;
	endfunction

	function automatic int idle_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 50;
		endcase
	endfunction

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WIDTH:  size_w = data[6:0];
			CFG_HEIGHT: size_h = data[6:0];
			CFG_DEPTH:  size_d = data[6:0];
			default:    vacuum = data;
		endcase
		@(posedge clk);
	endtask

	task automatic issue(in_item_t it, bit typed, out_item_t want);
		out_item_t pred;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pred = apply_command(it);
		due_results.push_back(typed ? want : pred);
	endtask

	task automatic check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t wanted;
		if (out_valid === 1'b1 && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result with no command pending: %p", out_item);
				errors++;
			end else begin
				wanted = due_results.pop_front();
				check_field("read_value", wanted.read_value, out_item.read_value);
				check_field("out_of_range", wanted.out_of_range, out_item.out_of_range);
				check_field("zone_valid", wanted.zone_valid, out_item.zone_valid);
				check_field("out_lo_x", wanted.out_lo_x, out_item.out_lo_x);
				check_field("out_lo_y", wanted.out_lo_y, out_item.out_lo_y);
				check_field("out_lo_z", wanted.out_lo_z, out_item.out_lo_z);
				check_field("out_hi_x", wanted.out_hi_x, out_item.out_hi_x);
				check_field("out_hi_y", wanted.out_hi_y, out_item.out_hi_y);
				check_field("out_hi_z", wanted.out_hi_z, out_item.out_hi_z);
			end
		end
		if (calm) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// includes the voxel-mark clearing pass after reset
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_count = 0;
		else
			quiet_count++;
		if (quiet_count >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [6:0]  wsz;
		logic [6:0]  hsz;
		logic [6:0]  dsz;
		logic [15:0] vac;

		// zero size at reset
		script.push_back(row_typed(point_cmd(CMD_READ, 0, 0, 0, 0), flags_result(16'h0, 1'b1)));
		script.push_back(row_typed(point_cmd(CMD_POP, 0, 0, 0, 0), flags_result(16'h0, 1'b0)));
		script.push_back(row_typed(point_cmd(CMD_WRITE, 63, 63, 63, 16'hFFFF),
			flags_result(16'h0, 1'b1)));
		// width above max edge, height at max edge
		script.push_back(row_reg(CFG_WIDTH, 16'd127));
		script.push_back(row_reg(CFG_HEIGHT, 16'd64));
		script.push_back(row_reg(CFG_DEPTH, 16'd1));
		script.push_back(row_reg(CFG_VACUUM, 16'hFFFF));
		script.push_back(row_item(point_cmd(CMD_WRITE, 63, 63, 0, 16'hFFFF), 1));
		script.push_back(row_item(point_cmd(CMD_READ, 63, 63, 0, 0), 1));
		script.push_back(row_typed(point_cmd(CMD_READ, 0, 0, 0, 0), flags_result(16'hFFFF, 1'b0)));
		script.push_back(row_typed(point_cmd(CMD_READ, 0, 0, 1, 0), flags_result(16'hFFFF, 1'b1)));
		script.push_back(row_typed(point_cmd(CMD_WRITE, 0, 0, 63, 16'h1234),
			flags_result(16'h0, 1'b1)));
		script.push_back(row_item(zone_cmd(CMD_PUSH,
			'{8'sh80, 8'sh80, 8'sh80, 8'sh7f, 8'sh7f, 8'sh7f}), 1));
		script.push_back(row_item(zone_cmd(CMD_PUSH,
			'{8'sh7f, 8'sh7f, 8'sh7f, 8'sh80, 8'sh80, 8'sh80}), 1));
		script.push_back(row_item(point_cmd(CMD_POP, 0, 0, 0, 0), 3));
		// ring wraps after a full set of pushes and reads as empty
		script.push_back(row_item(zone_cmd(CMD_PUSH,
			'{8'sd1, 8'sd2, 8'sd3, 8'sd4, 8'sd5, 8'sd6}), 16));
		script.push_back(row_typed(point_cmd(CMD_POP, 0, 0, 0, 0), flags_result(16'h0, 1'b0)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_reg(script[i].reg_idx, script[i].reg_data);
			else
				repeat (script[i].reps) issue(script[i].item, script[i].typed, script[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			vac = 16'($urandom);
			case (p)
				0: begin
					{wsz, hsz, dsz} = {7'd64, 7'd64, 7'd64};
					vac = 16'hFFFF;
				end
				1: begin
					{wsz, hsz, dsz} = {7'd127, 7'd127, 7'd127};
					vac = 16'h0000;
				end
				2: {wsz, hsz, dsz} = {7'd0, 7'($urandom_range(1, 8)), 7'($urandom_range(1, 8))};
				3: {wsz, hsz, dsz} = {7'd1, 7'd1, 7'd1};
				4: {wsz, hsz, dsz} = {7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
					7'($urandom_range(1, 8))};
				5: {wsz, hsz, dsz} = {7'd64, 7'd1, 7'd127};
				6: {wsz, hsz, dsz} = {7'd3, 7'd64, 7'd2};
				7: {wsz, hsz, dsz} = {7'($urandom), 7'($urandom), 7'($urandom)};
				8: {wsz, hsz, dsz} = {7'($urandom_range(2, 6)), 7'($urandom_range(2, 6)),
					7'($urandom_range(2, 6))};
				default: {wsz, hsz, dsz} = {7'd127, 7'd3, 7'd64};
			endcase
			// upper data bits of the size registers are don't-care
			write_reg(CFG_WIDTH, {9'($urandom), wsz});
			write_reg(CFG_HEIGHT, {9'($urandom), hsz});
			write_reg(CFG_DEPTH, {9'($urandom), dsz});
			write_reg(CFG_VACUUM, vac);
			calm = (p == PHASES - 1);
			gap_pct = calm ? 0 : idle_rate();
			stall_pct = calm ? 0 : idle_rate();
			push_pct = $urandom_range(5, 30);
			recent.delete();
			repeat (PHASE_ITEMS) begin
				if (!calm && $urandom_range(0, 99) == 0)
					wait_results_drained();
				issue(random_command(), 1'b0, '0);
			end
		end

		wait_results_drained();
		repeat (16) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/vsdzq_pkg.sv
rtl/core/vsdzq_ring.sv
rtl/core/voxel_store_dirty_zone_queue_core.sv
rtl/core/vsdzq_checker.sv
tb/tb_top.sv
